// File: design/mcfp_pkg.sv
// Shared types and constants for the motor command frame parser.
// No dependencies; used by mcfp_mode_store, motor_command_frame_parser_core, the checker and testbench.
package mcfp_pkg;

	localparam int MAX_MOTORS = 8;
	localparam int IDX_W      = $clog2(MAX_MOTORS);   // motor address width
	localparam int CNT_W      = 4;                    // motor_count / motor_index width

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);
	localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_MOTORS);
	localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(MAX_MOTORS - 1);

	// header and command bytes
	localparam logic [7:0] HDR_SYNC  = 8'hFF;
	localparam logic [7:0] HDR_ID    = 8'hFD;
	localparam logic [7:0] HDR_RSVD  = 8'h00;
	localparam logic [7:0] CMD_MODES = 8'h01;
	localparam logic [7:0] CMD_TGTS  = 8'h02;

	// stored motor modes that produce a target
	localparam logic [7:0] MODE_CURRENT  = 8'h02;
	localparam logic [7:0] MODE_VELOCITY = 8'h03;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_HDR2    = 3'd2,
		PH_HDR3    = 3'd3,
		PH_CMD     = 3'd4,
		PH_MODES   = 3'd5,
		PH_TARGETS = 3'd6
	} parse_phase_t;

	typedef enum logic [1:0] {
		ACT_SET_MODE     = 2'd0,
		ACT_SET_CURRENT  = 2'd1,
		ACT_SET_VELOCITY = 2'd2
	} action_t;

	// write request into the mode store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} mode_wr_t;

	// read request into the mode store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mode_rd_t;

endpackage

// File: design/mcfp_mode_store.sv
// Per-motor mode memory: one write port, one registered read port.
// Entries read as zero until written (valid bit per entry). Depends on mcfp_pkg.
module mcfp_mode_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcfp_pkg::mode_wr_t        wr,
	input  mcfp_pkg::mode_rd_t        rd,
	output logic [7:0]                rd_data
);

	logic [7:0]                     mem_q [mcfp_pkg::MAX_MOTORS];
	logic [mcfp_pkg::MAX_MOTORS-1:0] valid_q;
	logic [7:0]                     rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// same-entry write wins on a colliding read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			if (wr.en && (wr.addr == rd.addr)) begin
				rd_data_q <= wr.data;
			end else if (valid_q[rd.addr]) begin
				rd_data_q <= mem_q[rd.addr];
			end else begin
				rd_data_q <= 8'h00;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/motor_command_frame_parser_core.sv
// Top level of the motor command frame parser.
// Depends on mcfp_pkg and mcfp_mode_store.

// One received byte is taken per transfer on the s_ side, one byte per clock
// sustained. The parser hunts for the header FF FF FD 00, then reads command
// bytes: command 01 is followed by one mode byte per motor (each is stored and
// reported as a set-mode action), command 02 by two little-endian target bytes
// per motor, reported as a current target (stored mode 2, raw, scaled 1/1638
// by the consumer) or a velocity target (mode 3); other modes swallow the bytes.
// Any other command restarts the header hunt. Results pass the registered
// mode memory read, then the output register. The sustained rate holds
// until the two-deep path (decode stage plus output register) is full and
// m_tready is low; then the input stalls. The user writes motor_count through
// cfg_we/cfg_wdata only while idle; the block does not enforce it;
// 0 acts as 1, values above 8 act as 8. No clearing pass is needed after reset.
module motor_command_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,   // motor_count
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] rx_byte
	// actions out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [2:0] motor, [10:3] mode_value,
	                                 // [26:11] target_value, [31:27] zero
	output logic [1:0]  m_tuser      // [1:0] action
);

	localparam int IW = mcfp_pkg::IDX_W;
	localparam int CW = mcfp_pkg::CNT_W;

	// ---------------------------------------------------------------
	// configuration and parse state
	// ---------------------------------------------------------------
	logic [CW-1:0]          count_q;
	mcfp_pkg::parse_phase_t phase_q, phase_d;
	logic [CW-1:0]          idx_q, idx_d;
	logic                   bph_q, bph_d;
	logic [7:0]             low_q, low_d;

	logic       in_xfer;
	logic [7:0] rx;
	logic [CW-1:0] count_eff;
	logic [IW-1:0] idx_c;
	logic [CW-1:0] idx_next;

	// decode stage
	logic          s1_valid_q;
	logic          mode_emit_s1;
	logic          tgt_s1;
	logic [IW-1:0] motor_s1;
	logic [7:0]    mode_byte_s1;
	logic [15:0]   target_s1;

	// candidate produced by this byte
	logic          cand;
	logic          cand_mode;

	// output register
	logic          out_valid_q;
	logic [1:0]    out_action_q;
	logic [IW-1:0] out_motor_q;
	logic [7:0]    out_mode_q;
	logic [15:0]   out_target_q;

	logic               s1_adv;
	logic               s1_emit;
	mcfp_pkg::action_t  s1_action;
	logic [7:0]         rd_mode;
	mcfp_pkg::mode_wr_t mem_wr;
	mcfp_pkg::mode_rd_t mem_rd;

	assign rx      = s_tdata;
	assign s1_adv  = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || s1_adv;
	assign in_xfer = s_tvalid && s_tready;

	// clamp register and index to the supported motor range
	always_comb begin
		if (count_q == '0) begin
			count_eff = CW'(1);
		end else if (count_q > mcfp_pkg::COUNT_MAX) begin
			count_eff = mcfp_pkg::COUNT_MAX;
		end else begin
			count_eff = count_q;
		end
		if (idx_q >= mcfp_pkg::COUNT_MAX) begin
			idx_c = mcfp_pkg::IDX_LAST;
		end else begin
			idx_c = idx_q[IW-1:0];
		end
		idx_next = CW'(idx_c) + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= mcfp_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// parse FSM
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mcfp_pkg::PH_HDR0;
			idx_q   <= '0;
			bph_q   <= 1'b0;
			low_q   <= '0;
		end else if (in_xfer) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			bph_q   <= bph_d;
			low_q   <= low_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		bph_d     = bph_q;
		low_d     = low_q;
		cand      = 1'b0;
		cand_mode = 1'b0;
		mem_wr    = '{en: 1'b0, addr: idx_c, data: rx};
		mem_rd    = '{en: 1'b0, addr: idx_c};
		unique case (phase_q)
			mcfp_pkg::PH_HDR0: begin
				phase_d = (rx == mcfp_pkg::HDR_SYNC) ? mcfp_pkg::PH_HDR1 : mcfp_pkg::PH_HDR0;
			end
			mcfp_pkg::PH_HDR1: begin
				phase_d = (rx == mcfp_pkg::HDR_SYNC) ? mcfp_pkg::PH_HDR2 : mcfp_pkg::PH_HDR0;
			end
			mcfp_pkg::PH_HDR2: begin
				phase_d = (rx == mcfp_pkg::HDR_ID) ? mcfp_pkg::PH_HDR3 : mcfp_pkg::PH_HDR0;
			end
			mcfp_pkg::PH_HDR3: begin
				phase_d = (rx == mcfp_pkg::HDR_RSVD) ? mcfp_pkg::PH_CMD : mcfp_pkg::PH_HDR0;
			end
			mcfp_pkg::PH_CMD: begin
				if (rx == mcfp_pkg::CMD_MODES) begin
					phase_d = mcfp_pkg::PH_MODES;
					idx_d   = '0;
				end else if (rx == mcfp_pkg::CMD_TGTS) begin
					phase_d = mcfp_pkg::PH_TARGETS;
					idx_d   = '0;
					bph_d   = 1'b0;
				end else begin
					phase_d = mcfp_pkg::PH_HDR0;
				end
			end
			mcfp_pkg::PH_MODES: begin
				mem_wr.en = in_xfer;
				cand      = 1'b1;
				cand_mode = 1'b1;
				idx_d     = idx_next;
				if (idx_next >= count_eff) begin
					phase_d = mcfp_pkg::PH_CMD;
				end
			end
			mcfp_pkg::PH_TARGETS: begin
				if (!bph_q) begin
					low_d = rx;
					bph_d = 1'b1;
				end else begin
					bph_d     = 1'b0;
					cand      = 1'b1;
					mem_rd.en = in_xfer;
					idx_d     = idx_next;
					if (idx_next >= count_eff) begin
						phase_d = mcfp_pkg::PH_CMD;
					end
				end
			end
			default: begin
				phase_d = mcfp_pkg::PH_HDR0;
			end
		endcase
	end

	mcfp_mode_store u_mode_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (rd_mode)
	);

	// ---------------------------------------------------------------
	// decode stage: mode memory data arrives here
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_xfer && cand) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && cand) begin
			mode_emit_s1 <= cand_mode;
			tgt_s1       <= !cand_mode;
			motor_s1     <= idx_c;
			mode_byte_s1 <= rx;
			target_s1    <= {rx, low_q};
		end
	end

	always_comb begin
		s1_emit   = 1'b0;
		s1_action = mcfp_pkg::ACT_SET_MODE;
		if (mode_emit_s1) begin
			s1_emit = 1'b1;
		end else if (tgt_s1 && (rd_mode == mcfp_pkg::MODE_CURRENT)) begin
			s1_emit   = 1'b1;
			s1_action = mcfp_pkg::ACT_SET_CURRENT;
		end else if (tgt_s1 && (rd_mode == mcfp_pkg::MODE_VELOCITY)) begin
			s1_emit   = 1'b1;
			s1_action = mcfp_pkg::ACT_SET_VELOCITY;
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q && s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q && s1_emit) begin
			out_action_q <= s1_action;
			out_motor_q  <= motor_s1;
			out_mode_q   <= mode_emit_s1 ? mode_byte_s1 : 8'h00;
			out_target_q <= mode_emit_s1 ? 16'h0000 : target_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_action_q;
	assign m_tdata  = {5'b0, out_target_q, out_mode_q, out_motor_q};

endmodule

// File: dv/mcfp_action_checker.sv
`timescale 1ns / 1ps
// Action checker for motor_command_frame_parser_core: follows byte and motor_count
// transfers, predicts each action and compares it with the m_ side. Depends on mcfp_pkg.
module mcfp_action_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          mismatch_count,
	output int          actions_pending,
	output int          actions_checked
);
	import mcfp_pkg::*;

	typedef struct packed {
		action_t     act;
		logic [2:0]  motor;
		logic [7:0]  mode_value;
		logic [15:0] target_value;
	} motor_action_t;

	parse_phase_t     phase;
	logic [CNT_W-1:0] motor_index;
	logic             high_byte_next;
	logic [7:0]       low_byte;
	logic [7:0]       modes [MAX_MOTORS];
	logic [CNT_W-1:0] motor_count;
	motor_action_t    expected_actions [$];
	motor_action_t    want;
	int               fails = 0;
	int               checked = 0;

	task automatic push_action(input action_t act, input logic [IDX_W-1:0] motor,
	                           input logic [7:0] mode, input logic [15:0] target);
		motor_action_t a;
		a.act          = act;
		a.motor        = motor;
		a.mode_value   = mode;
		a.target_value = target;
		expected_actions.insert(expected_actions.size(), a);
	endtask

	task automatic note_mismatch(input string msg);
		fails++;
		if (fails <= 10)
			$display("%t mismatch: %s", $realtime, msg);
	endtask

	// advance the parser by one received byte, queue the action it causes
	task automatic parse_rx_byte(input logic [7:0] b);
		logic [CNT_W-1:0] eff;
		logic [IDX_W-1:0] idx;
		eff = (motor_count == '0) ? CNT_W'(1) :
		      (motor_count > COUNT_MAX) ? COUNT_MAX : motor_count;
		idx = (motor_index >= COUNT_MAX) ? IDX_LAST : motor_index[IDX_W-1:0];
		case (phase)
			PH_HDR0: phase = (b == HDR_SYNC) ? PH_HDR1 : PH_HDR0;
			PH_HDR1: phase = (b == HDR_SYNC) ? PH_HDR2 : PH_HDR0;
			PH_HDR2: phase = (b == HDR_ID) ? PH_HDR3 : PH_HDR0;
			PH_HDR3: phase = (b == HDR_RSVD) ? PH_CMD : PH_HDR0;
			PH_CMD: begin
				if (b == CMD_MODES) begin
					phase       = PH_MODES;
					motor_index = '0;
				end else if (b == CMD_TGTS) begin
					phase          = PH_TARGETS;
					motor_index    = '0;
					high_byte_next = 1'b0;
				end else begin
					phase = PH_HDR0;
				end
			end
			PH_MODES: begin
				modes[idx] = b;
				push_action(ACT_SET_MODE, idx, b, 16'h0000);
				motor_index = CNT_W'(idx) + 1'b1;
				if (motor_index >= eff)
					phase = PH_CMD;
			end
			PH_TARGETS: begin
				if (!high_byte_next) begin
					low_byte       = b;
					high_byte_next = 1'b1;
				end else begin
					high_byte_next = 1'b0;
					// modes other than current and velocity swallow the pair
					if (modes[idx] == MODE_CURRENT)
						push_action(ACT_SET_CURRENT, idx, 8'h00, {b, low_byte});
					else if (modes[idx] == MODE_VELOCITY)
						push_action(ACT_SET_VELOCITY, idx, 8'h00, {b, low_byte});
					motor_index = CNT_W'(idx) + 1'b1;
					if (motor_index >= eff)
						phase = PH_CMD;
				end
			end
			default: phase = PH_HDR0;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase          = PH_HDR0;
			motor_index    = '0;
			high_byte_next = 1'b0;
			low_byte       = '0;
			for (int i = 0; i < MAX_MOTORS; i++)
				modes[i] = '0;
			motor_count = COUNT_RESET;
			expected_actions.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_actions.size() == 0) begin
					note_mismatch($sformatf("unexpected action %0d motor %0d mode %0d target %0d",
						m_tuser, m_tdata[2:0], m_tdata[10:3], $signed(m_tdata[26:11])));
				end else begin
					want = expected_actions.pop_front();
					checked++;
					if (m_tuser !== want.act || m_tdata[2:0] !== want.motor ||
					    m_tdata[10:3] !== want.mode_value ||
					    m_tdata[26:11] !== want.target_value || m_tdata[31:27] !== 5'd0) begin
						note_mismatch($sformatf(
							"exp act %0d motor %0d mode %0d target %0d, got act %0d motor %0d mode %0d target %0d pad %0h",
							want.act, want.motor, want.mode_value, $signed(want.target_value),
							m_tuser, m_tdata[2:0], m_tdata[10:3], $signed(m_tdata[26:11]),
							m_tdata[31:27]));
					end
				end
			end
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata);
			if (cfg_we)
				motor_count = cfg_wdata;
		end
		mismatch_count  <= fails;
		actions_pending <= expected_actions.size();
		actions_checked <= checked;
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for motor_command_frame_parser_core: clock, reset, byte stimulus,
// motor_count writes and the verdict. Depends on mcfp_pkg, the core and mcfp_action_checker.
module testbench;
	import mcfp_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;   // result path plus margin

	// commands that drop back to header hunting
	localparam logic [7:0] CMD_RESYNC_ZERO = 8'h00;
	localparam logic [7:0] CMD_RESYNC      = 8'hFE;

	// motor_count per random phase, phase 0 in the low nibble
	localparam logic [47:0] COUNT_PLAN = {4'd8, 4'd4, 4'd7, 4'd5, 4'd6, 4'd2,
	                                      4'd9, 4'd3, 4'd15, 4'd0, 4'd8, 4'd1};
	localparam int PHASE_BYTES = 38;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = 4'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	int          mismatch_count;
	int          actions_pending;
	int          actions_checked;
	int          tx_idle_pct = 30;
	int          rx_idle_pct = 69;
	int          byte_budget = 0;
	int          bytes_sent = 0;
	int          cycles = 0;
	logic [3:0]  cur_count = COUNT_RESET;

	motor_command_frame_parser_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	mcfp_action_checker action_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_count),
		.actions_pending (actions_pending),
		.actions_checked (actions_checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// one byte transfer, with random sender gaps; skipped once the phase budget is spent
	task automatic send_byte(input logic [7:0] b);
		if (byte_budget > 0) begin
			byte_budget--;
			while ($urandom_range(99) < tx_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= b;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			bytes_sent++;
		end
	endtask

	// motor_count is written only with no action outstanding and the pipe drained
	task automatic write_count(input logic [3:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (actions_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_count = v;
	endtask

	// header, a few command bodies sized for the current count, then mostly a resync command
	task automatic send_frame();
		logic [7:0] hdr [4];
		int         eff;
		int         n_cmds;
		int         c;
		int         k;
		int         r;
		hdr[0] = HDR_SYNC;
		hdr[1] = HDR_SYNC;
		hdr[2] = HDR_ID;
		hdr[3] = HDR_RSVD;
		if ($urandom_range(9) == 0)
			hdr[$urandom_range(3)] = 8'($urandom_range(255));
		for (k = 0; k < 4; k++)
			send_byte(hdr[k]);
		eff = (cur_count == 0) ? 1 : (cur_count > COUNT_MAX) ? MAX_MOTORS : cur_count;
		n_cmds = $urandom_range(4, 1);
		for (c = 0; c < n_cmds; c++) begin
			if ($urandom_range(99) < 45) begin
				send_byte(CMD_MODES);
				for (k = 0; k < eff; k++) begin
					if ($urandom_range(24) == 0)
						break;   // truncated body
					if ($urandom_range(4) != 0)
						send_byte(8'($urandom_range(4)));
					else
						send_byte(8'($urandom_range(255)));
				end
			end else begin
				send_byte(CMD_TGTS);
				for (k = 0; k < eff; k++) begin
					if ($urandom_range(24) == 0)
						break;
					case ($urandom_range(9))
						0: begin
							send_byte(8'h00);
							send_byte(8'h80);
						end
						1: begin
							send_byte(8'hFF);
							send_byte(8'h7F);
						end
						default: begin
							send_byte(8'($urandom_range(255)));
							send_byte(8'($urandom_range(255)));
						end
					endcase
				end
			end
		end
		r = $urandom_range(99);
		if (r < 40)
			send_byte(CMD_RESYNC);
		else if (r < 75)
			send_byte(CMD_RESYNC_ZERO);
		else if (r < 90)
			send_byte(8'($urandom_range(253, 3)));   // unknown command
	endtask

	initial begin
		int p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset count of four
		byte_budget = 32;
		// third header byte FF where FD belongs: no sync
		send_byte(HDR_SYNC);
		send_byte(HDR_SYNC);
		send_byte(HDR_SYNC);
		send_byte(HDR_ID);
		send_byte(HDR_RSVD);
		send_byte(HDR_SYNC);
		send_byte(HDR_SYNC);
		send_byte(HDR_ID);
		send_byte(HDR_RSVD);
		// modes: current, velocity, out-of-range 0xFF, idle
		send_byte(CMD_MODES);
		send_byte(MODE_CURRENT);
		send_byte(MODE_VELOCITY);
		send_byte(8'hFF);
		send_byte(8'h00);
		// most negative current, most positive velocity, two silent pairs
		send_byte(CMD_TGTS);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h34);
		send_byte(8'h12);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(CMD_RESYNC);

		// random phases; count changes may land in the middle of a body
		for (p = 0; p < 12; p++) begin
			if (p == 4) begin
				tx_idle_pct <= 69;
				rx_idle_pct <= 30;
			end
			if (p == 8) begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
			write_count(COUNT_PLAN[p*4 +: 4]);
			byte_budget = PHASE_BYTES;
			while (byte_budget > 0) begin
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
				send_frame();
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (actions_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Summary: %0d bytes sent, directed frames plus twelve motor_count settings 0..15,",
			bytes_sent);
		$display("Summary: %0d actions compared under three sender/receiver stall mixes.",
			actions_checked);
		if (mismatch_count == 0 && actions_pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d actions outstanding", mismatch_count, actions_pending);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
